### hw/rtl/max_ones_rectangle_area_top_macros.svh
// Assertion macros shared by the rectangle-area block.
`ifndef MAX_ONES_RECTANGLE_AREA_TOP_MACROS_SVH
`define MAX_ONES_RECTANGLE_AREA_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MORA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MORA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mora_pkg.sv
// Shared types and constants of the rectangle-area block.
`timescale 1ns / 1ps
package mora_pkg;

  localparam int AREA_W = 17;
  localparam int AREA_MAX = 131071;
  localparam int CFG_W = 7;
  localparam int CFG_RESET = 64;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_LRD,
    ST_LHI,
    ST_LCMP,
    ST_RRD,
    ST_RHI,
    ST_RCMP,
    ST_RMUL,
    ST_RBEST,
    ST_EMIT
  } mora_state_t;

  // One accepted input word.
  typedef struct packed {
    logic cell_bit;
    logic last_cell;
  } mora_item_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [AREA_W-1:0] area;
  } mora_emit_t;

endpackage

### hw/rtl/mora_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
module mora_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with the read data registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mora_seq.sv
// Sequencer: height update per cell and the two bound passes per row.
`timescale 1ns / 1ps
module mora_seq #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mora_pkg::mora_item_t                item,
  input  logic [$clog2(MAX_COLS+1)-1:0]       row_n,
  output mora_pkg::mora_emit_t                emit,
  input  logic                                emit_ready
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int BW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int PW = HW + BW;
  localparam int XW = PW + mora_pkg::AREA_W;

  mora_pkg::mora_state_t state, state_next;

  logic [CW-1:0]               column_position;
  logic [CW-1:0]               cur;
  logic                        bit_q;
  logic                        last_q;
  logic [BW-1:0]               idx;
  logic [BW-1:0]               k;
  logic [HW-1:0]               hi;
  logic [BW-1:0]               lc;
  logic [PW-1:0]               prod;
  logic [mora_pkg::AREA_W-1:0] best;
  logic [MAX_COLS-1:0]         hvalid;
  logic                        hv_q;

  // Memory ports.
  logic [CW-1:0] raddr;
  logic [CW-1:0] waddr;
  logic          h_we, l_we, r_we;
  logic [HW-1:0] h_wdata, h_rdata, hrd;
  logic [BW-1:0] l_wdata, l_rdata;
  logic [BW-1:0] r_wdata, r_rdata;

  // Combinational helpers.
  logic [BW-1:0]               pos_eff;
  logic [HW-1:0]               h_new;
  logic [BW-1:0]               idx_inc;
  logic [BW-1:0]               knew;
  logic [XW-1:0]               prod_ext;
  logic [mora_pkg::AREA_W-1:0] area_sat;
  logic                        accept;

  mora_ram #(.DEPTH(MAX_COLS), .WIDTH(HW), .AW(CW)) u_height (
    .clk(clk), .we(h_we), .waddr(waddr), .wdata(h_wdata), .raddr(raddr), .rdata(h_rdata)
  );
  mora_ram #(.DEPTH(MAX_COLS), .WIDTH(BW), .AW(CW)) u_left (
    .clk(clk), .we(l_we), .waddr(waddr), .wdata(l_wdata), .raddr(raddr), .rdata(l_rdata)
  );
  mora_ram #(.DEPTH(MAX_COLS), .WIDTH(BW), .AW(CW)) u_right (
    .clk(clk), .we(r_we), .waddr(waddr), .wdata(r_wdata), .raddr(raddr), .rdata(r_rdata)
  );

  // A height entry never written since the last clear reads as zero.
  assign hrd = hv_q ? h_rdata : '0;

  // The current column is clamped to the last column of the row.
  assign pos_eff = (BW'(column_position) >= row_n) ? (row_n - BW'(1)) : BW'(column_position);
  assign accept = in_valid && in_ready;
  assign in_ready = (state == mora_pkg::ST_IDLE);
  assign idx_inc = idx + BW'(1);

  // New height of the current column, saturating at the row bound.
  always_comb begin
    if (!bit_q) begin
      h_new = '0;
    end else if (32'(hrd) < MAX_ROWS) begin
      h_new = hrd + HW'(1);
    end else begin
      h_new = HW'(MAX_ROWS);
    end
  end

  // Saturated area of the product register.
  assign prod_ext = XW'(prod);
  assign area_sat = (prod_ext > XW'(mora_pkg::AREA_MAX)) ?
                    mora_pkg::AREA_W'(mora_pkg::AREA_MAX) : prod_ext[mora_pkg::AREA_W-1:0];

  // Next bound candidate during a jump.
  always_comb begin
    unique case (state)
      mora_pkg::ST_LCMP: knew = l_rdata;
      mora_pkg::ST_RCMP: knew = r_rdata;
      mora_pkg::ST_RHI:  knew = idx_inc;
      default:           knew = k;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      mora_pkg::ST_IDLE: begin
        if (accept) state_next = mora_pkg::ST_CELL;
      end
      mora_pkg::ST_CELL: begin
        if ((BW'(cur) + BW'(1) >= row_n) || last_q) state_next = mora_pkg::ST_LRD;
        else state_next = mora_pkg::ST_IDLE;
      end
      mora_pkg::ST_LRD: state_next = mora_pkg::ST_LHI;
      mora_pkg::ST_LHI: begin
        if (idx == '0) state_next = (idx_inc >= row_n) ? mora_pkg::ST_RRD : mora_pkg::ST_LRD;
        else state_next = mora_pkg::ST_LCMP;
      end
      mora_pkg::ST_LCMP: begin
        if ((hi <= hrd) && (knew != '0)) state_next = mora_pkg::ST_LCMP;
        else state_next = (idx_inc >= row_n) ? mora_pkg::ST_RRD : mora_pkg::ST_LRD;
      end
      mora_pkg::ST_RRD: state_next = mora_pkg::ST_RHI;
      mora_pkg::ST_RHI: begin
        state_next = (knew >= row_n) ? mora_pkg::ST_RMUL : mora_pkg::ST_RCMP;
      end
      mora_pkg::ST_RCMP: begin
        if ((hrd >= hi) && (knew < row_n)) state_next = mora_pkg::ST_RCMP;
        else state_next = mora_pkg::ST_RMUL;
      end
      mora_pkg::ST_RMUL: state_next = mora_pkg::ST_RBEST;
      mora_pkg::ST_RBEST: begin
        if (idx != '0) state_next = mora_pkg::ST_RRD;
        else if (last_q) state_next = mora_pkg::ST_EMIT;
        else state_next = mora_pkg::ST_IDLE;
      end
      mora_pkg::ST_EMIT: begin
        if (emit_ready) state_next = mora_pkg::ST_IDLE;
      end
      default: state_next = mora_pkg::ST_IDLE;
    endcase
  end

  // Output logic: memory addresses, write enables and the result word.
  always_comb begin
    raddr = idx[CW-1:0];
    waddr = idx[CW-1:0];
    h_we = 1'b0;
    l_we = 1'b0;
    r_we = 1'b0;
    h_wdata = h_new;
    l_wdata = '0;
    r_wdata = k;
    emit.valid = 1'b0;
    emit.area = best;
    unique case (state)
      mora_pkg::ST_IDLE: raddr = pos_eff[CW-1:0];
      mora_pkg::ST_CELL: begin
        waddr = cur;
        h_we = 1'b1;
      end
      mora_pkg::ST_LHI: begin
        if (idx == '0) l_we = 1'b1;
        else raddr = CW'(idx - BW'(1));
      end
      mora_pkg::ST_LCMP: begin
        if (hi <= hrd) begin
          if (knew == '0) l_we = 1'b1;
          else raddr = CW'(knew - BW'(1));
        end else begin
          l_we = 1'b1;
          l_wdata = k;
        end
      end
      mora_pkg::ST_RHI: raddr = knew[CW-1:0];
      mora_pkg::ST_RCMP: raddr = knew[CW-1:0];
      mora_pkg::ST_RMUL: r_we = 1'b1;
      mora_pkg::ST_EMIT: emit.valid = 1'b1;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mora_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: column position, valid bits and best area.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      hvalid <= '0;
      best <= '0;
    end else begin
      unique case (state)
        mora_pkg::ST_CELL: begin
          hvalid[cur] <= 1'b1;
          if ((BW'(cur) + BW'(1) >= row_n) || last_q) begin
            column_position <= '0;
            // Cells missing from a short final row count as zeros.
            if (last_q) begin
              for (int c = 0; c < MAX_COLS; c++) begin
                if (c > 32'(cur)) hvalid[c] <= 1'b0;
              end
            end
          end else begin
            column_position <= cur + CW'(1);
          end
        end
        mora_pkg::ST_RBEST: begin
          if (area_sat > best) best <= area_sat;
        end
        mora_pkg::ST_EMIT: begin
          if (emit_ready) begin
            best <= '0;
            hvalid <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    hv_q <= hvalid[raddr];
    unique case (state)
      mora_pkg::ST_IDLE: begin
        cur <= pos_eff[CW-1:0];
        bit_q <= item.cell_bit;
        last_q <= item.last_cell;
      end
      mora_pkg::ST_CELL: idx <= '0;
      mora_pkg::ST_LHI: begin
        hi <= hrd;
        k <= idx;
        if (idx == '0) idx <= (idx_inc >= row_n) ? (row_n - BW'(1)) : idx_inc;
      end
      mora_pkg::ST_LCMP: begin
        if ((hi <= hrd) && (knew != '0)) k <= knew;
        else idx <= (idx_inc >= row_n) ? (row_n - BW'(1)) : idx_inc;
      end
      mora_pkg::ST_RHI: begin
        hi <= hrd;
        lc <= l_rdata;
        k <= knew;
      end
      mora_pkg::ST_RCMP: begin
        if (hrd >= hi) k <= knew;
      end
      mora_pkg::ST_RMUL: prod <= PW'(hi) * PW'(k - lc);
      mora_pkg::ST_RBEST: begin
        if (idx != '0) idx <= idx - BW'(1);
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/max_ones_rectangle_area_top.sv
// Top level of the streaming largest all-ones rectangle block.
//
//   channel  direction  handshake             word
//   in       sink       in_valid / in_ready   cell_bit, last_cell
//   out      source     out_valid / out_ready max_area
//   cfg      sink       cfg_valid / cfg_ready column_count
//
// A cell is a height read followed by its write back.
// At a row end the left pass reads and compares each column, and the right pass also
// multiplies and updates the best area; each bound jump repeats the compare.
// A result then waits to enter the output register while that register is full.
// Reset is synchronous and clears the heights through per-column valid bits, so
// the block accepts words right after reset.
`timescale 1ns / 1ps
`include "max_ones_rectangle_area_top_macros.svh"
module max_ones_rectangle_area_top #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cell_bit,
  input  logic                          last_cell,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mora_pkg::AREA_W-1:0]   max_area,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mora_pkg::CFG_W-1:0]    column_count
);

  localparam int BW = $clog2(MAX_COLS + 1);

  logic [mora_pkg::CFG_W-1:0] col_cfg;
  logic [BW-1:0]              row_n;
  mora_pkg::mora_item_t       item;
  mora_pkg::mora_emit_t       emit;
  logic                       emit_ready;

  // Width register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cfg <= mora_pkg::CFG_W'(mora_pkg::CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      col_cfg <= column_count;
    end
  end

  // Effective row width: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (col_cfg == '0) begin
      row_n = BW'(1);
    end else if (32'(col_cfg) > MAX_COLS) begin
      row_n = BW'(MAX_COLS);
    end else begin
      row_n = BW'(col_cfg);
    end
  end

  assign item.cell_bit = cell_bit;
  assign item.last_cell = last_cell;

  mora_seq #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item(item),
    .row_n(row_n),
    .emit(emit),
    .emit_ready(emit_ready)
  );

  // Output register.
  assign emit_ready = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      max_area <= emit.area;
    end
  end

  `MORA_ASSERT_NOW(a_no_input_during_result, emit.valid, !in_ready, "input taken while a result is pending")
  `MORA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second word taken before the first was processed")
  `MORA_ASSERT_NEXT(a_result_loaded, emit.valid && emit_ready, out_valid && (max_area == $past(emit.area)), "result not loaded into the output register")

endmodule

### bench/mora_checker.sv
// Checker for the rectangle-area block: predicts each area and compares it.
`timescale 1ns / 1ps
module mora_checker #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cell_bit,
  input  logic                        last_cell,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mora_pkg::AREA_W-1:0] max_area,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mora_pkg::CFG_W-1:0]  column_count,
  output int                          fail_count,
  output int                          pending_areas,
  output int                          areas_seen
);

  logic [mora_pkg::CFG_W-1:0]  width_reg;
  int unsigned                 heights [MAX_COLS];
  int unsigned                 lefts [MAX_COLS];
  int unsigned                 rights [MAX_COLS];
  int unsigned                 best;
  int unsigned                 col_pos;
  logic [mora_pkg::AREA_W-1:0] area_queue [$];

  assign pending_areas = area_queue.size();

  // Effective row width after clamping the register.
  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  // Nearest-shorter-bound passes and best-area update for one finished row.
  task automatic scan_row(input int unsigned n);
    int unsigned k;
    int unsigned c;
    longint unsigned a;
    for (int unsigned i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && heights[i] <= heights[k-1]) k = lefts[k-1];
      lefts[i] = k;
    end
    for (int unsigned i = n; i > 0; i--) begin
      c = i - 1;
      k = c + 1;
      while (k < n && heights[c] <= heights[k]) k = rights[k];
      rights[c] = k;
      a = longint'(heights[c]) * longint'(k - lefts[c]);
      if (a > mora_pkg::AREA_MAX) a = mora_pkg::AREA_MAX;
      if (a > best) best = 32'(a);
    end
  endtask

  // Advance the predicted matrix state by one cell.
  task automatic take_cell(input logic bit_v, input logic last_v);
    int unsigned n;
    int unsigned p;
    n = eff_width();
    p = col_pos;
    if (p >= n) p = n - 1;
    if (!bit_v) heights[p] = 0;
    else if (heights[p] < MAX_ROWS) heights[p]++;
    if (p + 1 >= n) begin
      scan_row(n);
      col_pos = 0;
    end else if (last_v) begin
      for (int unsigned c = p + 1; c < n; c++) heights[c] = 0;
      scan_row(n);
      col_pos = 0;
    end else begin
      col_pos = p + 1;
    end
    if (last_v) begin
      area_queue.insert(area_queue.size(), best[mora_pkg::AREA_W-1:0]);
      for (int c = 0; c < MAX_COLS; c++) heights[c] = 0;
      best = 0;
      col_pos = 0;
    end
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      width_reg = mora_pkg::CFG_W'(mora_pkg::CFG_RESET);
      for (int c = 0; c < MAX_COLS; c++) begin
        heights[c] = 0;
        lefts[c] = 0;
        rights[c] = 0;
      end
      best = 0;
      col_pos = 0;
      area_queue.delete();
      fail_count = 0;
      areas_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) width_reg = column_count;
      if (in_valid && in_ready) take_cell(cell_bit, last_cell);
      if (out_valid && out_ready) begin
        areas_seen++;
        if (area_queue.size() == 0) begin
          $display("%0t: unexpected area word, expected none, actual %0d", $time, max_area);
          fail_count++;
        end else begin
          if (max_area !== area_queue[0]) begin
            $display("%0t: max_area mismatch, expected %0d, actual %0d",
                     $time, area_queue[0], max_area);
            fail_count++;
          end
          void'(area_queue.pop_front());
        end
      end
    end
  end
endmodule

### bench/tb_max_ones_rectangle_area_top.sv
// Stimulus and verdict for the rectangle-area block.
`timescale 1ns / 1ps
module tb_max_ones_rectangle_area_top;

  localparam int WATCH_LIMIT = 20000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        cell_bit = 1'b0;
  logic                        last_cell = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [mora_pkg::AREA_W-1:0] max_area;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mora_pkg::CFG_W-1:0]  column_count = '0;
  int                          fail_count;
  int                          pending_areas;
  int                          areas_seen;
  int                          cells_sent = 0;
  int                          idle_cycles = 0;
  int                          width_writes = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  max_ones_rectangle_area_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cell_bit(cell_bit), .last_cell(last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .max_area(max_area),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .column_count(column_count)
  );

  mora_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cell_bit(cell_bit), .last_cell(last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .max_area(max_area),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .column_count(column_count),
    .fail_count(fail_count), .pending_areas(pending_areas), .areas_seen(areas_seen)
  );

  // Send one cell word after an optional random gap and wait for its acceptance.
  // Valid drops only for a real gap, so back-to-back words keep it high.
  task automatic send_cell(input logic bit_v, input logic last_v, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_bit <= bit_v;
    last_cell <= last_v;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    @(negedge clk);
  endtask

  // Stop sending, wait until every area is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_areas != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  // Write the row width while the block is idle.
  task automatic write_width(input logic [mora_pkg::CFG_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    column_count <= w;
    do @(posedge clk); while (!cfg_ready);
    width_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One matrix of random content; density and size are drawn per matrix.
  task automatic send_matrix(input int cells, input bit gaps);
    int dens;
    dens = $urandom_range(0, 100);
    for (int i = 0; i < cells; i++)
      send_cell(($urandom_range(0, 99) < dens), i == cells - 1, gaps);
  endtask

  // Receiver: random stall before taking each word, with quiet stretches.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("max_ones_rectangle_area_top test failed");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [mora_pkg::CFG_W-1:0] widths [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd3};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full ones at width 64, lone last cell, mid-row last, zero cells.
    for (int i = 0; i < 8; i++) send_cell(1'b1, i == 7, 1'b0);
    send_cell(1'b0, 1'b1, 1'b0);
    send_cell(1'b1, 1'b1, 1'b0);
    write_width(7'd4);
    for (int i = 0; i < 10; i++) send_cell(1'b1, i == 9, 1'b1);
    write_width(7'd1);
    for (int i = 0; i < 5; i++) send_cell(1'b1, i == 4, 1'b0);

    // Tall column: height saturates at the row bound.
    for (int i = 0; i < 1030; i++) send_cell(1'b1, i == 1029, 1'b0);

    // Width change mid-row: drop from 6 to 2 with a partial row present.
    write_width(7'd6);
    for (int i = 0; i < 4; i++) send_cell(1'b1, 1'b0, 1'b0);
    drain();
    cfg_valid <= 1'b1;
    column_count <= 7'd2;
    do @(posedge clk); while (!cfg_ready);
    width_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 4; i++) send_cell(1'b1, i == 3, 1'b0);

    // Random phases across widths, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_width(widths[ph]);
      for (int m = 0; m < 8; m++) begin
        send_matrix($urandom_range(1, 20), (m % 3) != 0);
        if (m == 4) drain();
      end
    end
    write_width(7'd8);
    while (cells_sent < 1950) send_matrix($urandom_range(1, 40), 1'b1);

    drain();
    $display("Sent %0d cells over %0d width writes; %0d area words checked.",
             cells_sent, width_writes, areas_seen);
    if (fail_count == 0 && pending_areas == 0) begin
      $display("max_ones_rectangle_area_top test passed");
    end else begin
      $display("max_ones_rectangle_area_top test failed");
    end
    $finish;
  end
endmodule

### max_ones_rectangle_area_top.f
+incdir+hw/rtl
hw/rtl/mora_pkg.sv
hw/rtl/mora_ram.sv
hw/rtl/mora_seq.sv
hw/rtl/max_ones_rectangle_area_top.sv
bench/mora_checker.sv
bench/tb_max_ones_rectangle_area_top.sv
